>>> rtl/bmp_rgb_threshold_stream_top_macros.svh
// assertion macros for the bmp threshold stream top level
`ifndef BMP_RGB_THRESHOLD_STREAM_TOP_MACROS_SVH
`define BMP_RGB_THRESHOLD_STREAM_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bmp_thr_pkg.sv
// shared types and constants for the bmp threshold stream
`timescale 1ns / 1ps

package bmp_thr_pkg;

    localparam int HEADER_BYTES = 54;
    localparam int WIDTH_FIRST  = 18;
    localparam int WIDTH_BYTES  = 4;
    localparam int POS_W        = 6;
    localparam int IMG_W        = 32;
    localparam int PIX_W        = IMG_W + 1;
    localparam int ROW_W        = IMG_W + 2;
    localparam int LIMIT_W      = 11;
    localparam int SUM_W        = 10;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] BYTE_BLACK = 8'h00;

    // pixel phase codes
    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    // one run of output bytes: a single byte, or one value sent three times
    typedef struct packed {
        logic [7:0] value;
        logic       triple;
    } run_t;

    // queue status seen by the top level
    typedef struct packed {
        logic       full;
        logic [1:0] count;
    } q_stat_t;

endpackage

>>> rtl/bmp_rgb_threshold_stream_top.sv
// top level of the bmp binary threshold byte stream
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  input    | in        | in_valid/in_stall  | byte_value, start_of_file
//  output   | out       | out_valid/out_stall| out_byte, last_of_run
//  config   | in        | sum_limit_wr_en    | sum_limit
//
// one input word per cycle while in_stall is low; results go to the run queue
// a red byte yields three output words from a two-run queue
// in_stall rises only while that queue holds two runs
// reset clears position state, width and queue; the limit resets to 382
`timescale 1ns / 1ps

`include "bmp_rgb_threshold_stream_top_macros.svh"

module bmp_rgb_threshold_stream_top
    import bmp_thr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_limit_wr_en,
    input  logic [LIMIT_W-1:0] sum_limit,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               start_of_file,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(382);

    logic [LIMIT_W-1:0] sum_limit_reg;
    logic               accept;
    logic               push;
    run_t               push_run;
    q_stat_t            q_stat;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_limit_reg <= LIMIT_RESET;
        end
        else if (sum_limit_wr_en)
        begin
            sum_limit_reg <= sum_limit;
        end
    end

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    // stream parsing and pixel decision
    bmp_thr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_value    (byte_value),
        .start_of_file (start_of_file),
        .sum_limit     (sum_limit_reg),
        .push          (push),
        .push_run      (push_run)
    );

    // output run queue
    bmp_thr_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_run    (push_run),
        .stat        (q_stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // checks
    `BMP_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count != 2'd3, "run queue count out of range")
    `BMP_ASSERT_NOW(a_push_room, push, !q_stat.full, "run pushed into full queue")
    `BMP_ASSERT_NOW(a_triple_val, out_valid && !last_of_run,
                    out_byte == BYTE_WHITE || out_byte == BYTE_BLACK,
                    "pixel run byte neither white nor black")
    `BMP_ASSERT_NEXT(a_push_seen, push, out_valid, "pushed run not shown at output")

endmodule

>>> rtl/bmp_thr_outq.sv
// two-entry run queue that serializes runs into output bytes
`timescale 1ns / 1ps

module bmp_thr_outq
    import bmp_thr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  run_t       push_run,
    output q_stat_t    stat,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    run_t       slot_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] bcnt_reg;
    logic [1:0] bcnt_next;
    logic       pop;
    logic       take;
    run_t       head;

    // head run and byte position within it
    assign head        = slot_reg[rd_ptr_reg];
    assign out_valid   = (count_reg != 2'd0);
    assign out_byte    = head.value;
    assign last_of_run = !head.triple || (bcnt_reg == 2'd2);
    assign take        = out_valid && !out_stall;
    assign pop         = take && last_of_run;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.count = count_reg;

    // pointer, count and byte counter updates
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            bcnt_next = 2'd0;
        end
        else if (take)
        begin
            bcnt_next = bcnt_reg + 2'd1;
        end
        else
        begin
            bcnt_next = bcnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            bcnt_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            bcnt_reg   <= bcnt_next;
        end
    end

    // run storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

>>> rtl/bmp_thr_core.sv
// header tracking, row position and pixel threshold for one input word
`timescale 1ns / 1ps

module bmp_thr_core
    import bmp_thr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_value,
    input  logic               start_of_file,
    input  logic [LIMIT_W-1:0] sum_limit,
    output logic               push,
    output run_t               push_run
);

    logic [POS_W-1:0] hdr_pos_reg;
    logic [POS_W-1:0] hdr_pos_next;
    logic [IMG_W-1:0] width_reg;
    logic [IMG_W-1:0] width_next;
    logic [ROW_W-1:0] row_off_reg;
    logic [ROW_W-1:0] row_off_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [7:0]       blue_reg;
    logic [7:0]       blue_next;
    logic [7:0]       green_reg;
    logic [7:0]       green_next;
    logic [PIX_W-1:0] pix_bytes_reg;
    logic [ROW_W-1:0] row_len_reg;
    logic             width_ok_reg;

    logic [POS_W-1:0] hp;
    logic [IMG_W-1:0] w_cur;
    logic [ROW_W-1:0] ro;
    logic [1:0]       ph;
    logic [POS_W-1:0] lane_pos;
    logic [1:0]       lane;
    logic [ROW_W-1:0] ro_step;
    logic [ROW_W-1:0] ro_add;
    logic [SUM_W-1:0] px_sum;
    logic             white;
    logic [PIX_W-1:0] pix_calc;
    logic [ROW_W-1:0] row_calc;

    // row geometry from the captured width, held registered in pix_bytes_reg and row_len_reg
    assign pix_calc = {1'b0, width_reg} + {width_reg, 1'b0};
    assign row_calc = ({1'b0, pix_calc} + ROW_W'(3)) & ~ROW_W'(3);

    // state as seen by this word, cleared on start of file
    assign hp    = start_of_file ? '0 : hdr_pos_reg;
    assign w_cur = start_of_file ? '0 : width_reg;
    assign ro    = start_of_file ? '0 : row_off_reg;
    assign ph    = start_of_file ? PH_BLUE : phase_reg;

    assign lane_pos = hp - POS_W'(WIDTH_FIRST);
    assign lane     = lane_pos[1:0];

    // pixel sum against the signed limit
    assign px_sum = {2'b00, blue_reg} + {2'b00, green_reg} + {2'b00, byte_value};
    assign white  = $signed({2'b00, px_sum}) > $signed({{(SUM_W+2-LIMIT_W){sum_limit[LIMIT_W-1]}},
                                                         sum_limit});

    assign ro_step = ph[1] ? ROW_W'(3) : ROW_W'(1);
    assign ro_add  = ro + ro_step;

    // per-word decision
    always_comb
    begin
        hdr_pos_next   = hp;
        width_next     = w_cur;
        row_off_next   = ro;
        phase_next     = ph;
        blue_next      = blue_reg;
        green_next     = green_reg;
        push           = 1'b0;
        push_run.value = byte_value;
        push_run.triple = 1'b0;
        if (hp < POS_W'(HEADER_BYTES))
        begin
            // header byte: copy, capture width bytes
            if (hp >= POS_W'(WIDTH_FIRST) && hp < POS_W'(WIDTH_FIRST + WIDTH_BYTES))
            begin
                width_next[8*lane +: 8] = byte_value;
            end
            hdr_pos_next = hp + POS_W'(1);
            push         = accept;
        end
        else if (!width_ok_reg)
        begin
            push = accept;
        end
        else if (ph == PH_GREEN)
        begin
            green_next = byte_value;
            phase_next = PH_RED;
        end
        else if (ph[1])
        begin
            // red byte closes the pixel
            phase_next      = PH_BLUE;
            row_off_next    = (ro_add >= row_len_reg) ? '0 : ro_add;
            push            = accept;
            push_run.value  = white ? BYTE_WHITE : BYTE_BLACK;
            push_run.triple = 1'b1;
        end
        else if (ro < {1'b0, pix_bytes_reg})
        begin
            blue_next  = byte_value;
            phase_next = PH_GREEN;
        end
        else
        begin
            // row padding
            row_off_next = (ro_add >= row_len_reg) ? '0 : ro_add;
            push         = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg   <= '0;
            width_reg     <= '0;
            row_off_reg   <= '0;
            phase_reg     <= PH_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            pix_bytes_reg <= '0;
            row_len_reg   <= '0;
            width_ok_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hdr_pos_reg <= hdr_pos_next;
                width_reg   <= width_next;
                row_off_reg <= row_off_next;
                phase_reg   <= phase_next;
                blue_reg    <= blue_next;
                green_reg   <= green_next;
            end
            pix_bytes_reg <= pix_calc;
            row_len_reg   <= row_calc;
            width_ok_reg  <= !width_reg[IMG_W-1] && (width_reg != '0);
        end
    end

endmodule

>>> tb/bmp_rgb_threshold_stream_top_tb.sv
// self-checking testbench for the bmp binary threshold byte stream
`timescale 1ns / 1ps

import bmp_thr_pkg::*;

// one expected output word
typedef struct packed {
    logic [7:0] value;
    logic       is_last;
} out_word_t;

// tracks header, row and pixel position and predicts the output words
class bmp_threshold_board;
    int          limit;
    int          hdr_pos;
    logic [31:0] img_width;
    logic [34:0] row_off;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    logic [1:0]  pix_phase;
    out_word_t   due_words[$];
    int          errors;
    int          words_checked;

    function new();
        limit = 382;  // register value after reset
        errors = 0;
        words_checked = 0;
        clear_file();
    endfunction

    function void clear_file();
        hdr_pos = 0;
        img_width = '0;
        row_off = '0;
        held_blue = '0;
        held_green = '0;
        pix_phase = PH_BLUE;
    endfunction

    function void set_limit(int v);
        limit = v;
    endfunction

    // account for one accepted input byte
    function void note_byte(logic [7:0] b, logic sof);
        logic [33:0] pix_bytes;
        logic [1:0]  pad;
        logic [34:0] row_len;
        logic [7:0]  shade;
        int          total;
        if (sof)
            clear_file();
        // header bytes pass through, width captured little-endian
        if (hdr_pos < HEADER_BYTES)
        begin
            if (hdr_pos >= WIDTH_FIRST && hdr_pos < WIDTH_FIRST + WIDTH_BYTES)
                img_width[8 * (hdr_pos - WIDTH_FIRST) +: 8] = b;
            hdr_pos++;
            due_words.push_back(out_word_t'{value: b, is_last: 1'b1});
            return;
        end
        // width zero or negative: plain copy
        if (img_width[31] || img_width == 0)
        begin
            due_words.push_back(out_word_t'{value: b, is_last: 1'b1});
            return;
        end
        pix_bytes = {2'b00, img_width} + {1'b0, img_width, 1'b0};
        pad = 2'b00 - pix_bytes[1:0];
        row_len = {1'b0, pix_bytes} + {33'd0, pad};
        if (pix_phase == PH_GREEN)
        begin
            held_green = b;
            pix_phase = PH_RED;
            return;
        end
        // red byte: three words of the thresholded shade
        if (pix_phase == PH_RED)
        begin
            total = int'(held_blue) + int'(held_green) + int'(b);
            shade = (total > limit) ? BYTE_WHITE : BYTE_BLACK;
            pix_phase = PH_BLUE;
            row_off = row_off + 35'd3;
            if (row_off >= row_len)
                row_off = '0;
            due_words.push_back(out_word_t'{value: shade, is_last: 1'b0});
            due_words.push_back(out_word_t'{value: shade, is_last: 1'b0});
            due_words.push_back(out_word_t'{value: shade, is_last: 1'b1});
            return;
        end
        if ({1'b0, row_off} < {2'b00, pix_bytes})
        begin
            held_blue = b;
            pix_phase = PH_GREEN;
            return;
        end
        // row padding passes through
        row_off = row_off + 35'd1;
        if (row_off >= row_len)
            row_off = '0;
        due_words.push_back(out_word_t'{value: b, is_last: 1'b1});
    endfunction

    task report(string msg);
        if (errors < 40)
            $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // compare one accepted output word with the oldest expectation
    task check_word(logic [7:0] v, logic is_last);
        out_word_t want;
        if (due_words.size() == 0)
        begin
            report($sformatf("unexpected word %02h last %b", v, is_last));
            return;
        end
        want = due_words.pop_front();
        words_checked++;
        if (v !== want.value)
            report($sformatf("out_byte %02h, expected %02h", v, want.value));
        if (is_last !== want.is_last)
            report($sformatf("last_of_run %b, expected %b", is_last, want.is_last));
    endtask
endclass

module bmp_rgb_threshold_stream_top_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int STUCK_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 64;

    typedef enum {FILE_ZERO, FILE_NEGATIVE, FILE_HUGE, FILE_SHORT_HEADER} odd_file_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               sum_limit_wr_en = 1'b0;
    logic [LIMIT_W-1:0] sum_limit = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         byte_value = '0;
    logic               start_of_file = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               last_of_run;

    bmp_threshold_board board = new();

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int limits_used = 0;

    bmp_rgb_threshold_stream_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sum_limit_wr_en (sum_limit_wr_en),
        .sum_limit       (sum_limit),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_value      (byte_value),
        .start_of_file   (start_of_file),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: long hold-off when asked, else random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor: note accepted input words, then check accepted output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_byte(byte_value, start_of_file);
            if (out_valid && !out_stall)
                board.check_word(out_byte, last_of_run);
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                 STUCK_LIMIT, board.due_words.size());
        $display("Test completed with failures");
        $finish;
    end

    // offer one word, with random gaps, and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic sof);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_value <= b;
        start_of_file <= sof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // header bytes, width at offsets 18 to 21, the rest random
    task automatic send_header(input logic [31:0] w, input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i >= WIDTH_FIRST && i < WIDTH_FIRST + WIDTH_BYTES)
                b = w[8 * (i - WIDTH_FIRST) +: 8];
            send_word(b, i == 0);
        end
        files_sent++;
    endtask

    task automatic send_rgb(input logic [7:0] bl, input logic [7:0] gr, input logic [7:0] rd);
        send_word(bl, 1'b0);
        send_word(gr, 1'b0);
        send_word(rd, 1'b0);
    endtask

    // pixel with extremes and sums right at the limit mixed in
    task automatic send_pixel();
        int bl;
        int gr;
        int rd;
        bl = $urandom_range(0, 255);
        gr = $urandom_range(0, 255);
        rd = $urandom_range(0, 255);
        case ($urandom_range(0, 7))
            0: send_rgb(BYTE_BLACK, BYTE_BLACK, BYTE_BLACK);
            1: send_rgb(BYTE_WHITE, BYTE_WHITE, BYTE_WHITE);
            2, 3:
            begin
                rd = board.limit - bl - gr + $urandom_range(0, 1);
                if (rd < 0)
                    rd = 0;
                if (rd > 255)
                    rd = 255;
                send_rgb(bl[7:0], gr[7:0], rd[7:0]);
            end
            default: send_rgb(bl[7:0], gr[7:0], rd[7:0]);
        endcase
    endtask

    // well-formed image, sometimes cut off inside a pixel
    task automatic send_image(input int w, input int rows);
        int pad;
        pad = (4 - (3 * w) % 4) % 4;
        send_header(w, HEADER_BYTES);
        for (int r = 0; r < rows; r++)
        begin
            for (int p = 0; p < w; p++)
                send_pixel();
            for (int k = 0; k < pad; k++)
                send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
                send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // odd files: non-positive or huge width, header cut short
    task automatic send_odd_file(input odd_file_t kind);
        logic [31:0] w;
        case (kind)
            FILE_ZERO:
            begin
                send_header(32'd0, HEADER_BYTES);
                repeat ($urandom_range(3, 8))
                    send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            FILE_NEGATIVE:
            begin
                case ($urandom_range(0, 2))
                    0: w = 32'h8000_0000;
                    1: w = 32'hFFFF_FFFF;
                    default: w = {1'b1, 31'($urandom)};
                endcase
                send_header(w, HEADER_BYTES);
                repeat ($urandom_range(3, 8))
                    send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            FILE_HUGE:
            begin
                w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : {1'b0, 31'($urandom)} | 32'h0001_0000;
                send_header(w, HEADER_BYTES);
                repeat ($urandom_range(2, 4))
                    send_pixel();
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            default:
                send_header($urandom_range(1, 7), $urandom_range(1, HEADER_BYTES - 1));
        endcase
    endtask

    // stop offering and wait until every expected word is out
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_limit(input int v);
        drain();
        sum_limit_wr_en <= 1'b1;
        sum_limit <= v[LIMIT_W-1:0];
        @(posedge clk);
        sum_limit_wr_en <= 1'b0;
        board.set_limit(v);
        limits_used++;
    endtask

    initial
    begin
        int lim;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: width 1 at the reset limit, black, white, at and just over the limit
        send_header(32'd1, HEADER_BYTES);
        send_rgb(8'd0, 8'd0, 8'd0);
        send_word(8'h00, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_word(8'hFF, 1'b0);
        send_rgb(8'd127, 8'd127, 8'd128);
        send_word(8'h5A, 1'b0);
        send_rgb(8'd127, 8'd127, 8'd129);
        send_word(8'hA5, 1'b0);
        // partial pixel dropped by a new file of width zero
        send_word(8'd200, 1'b0);
        send_word(8'd201, 1'b0);
        send_odd_file(FILE_ZERO);

        // one stretch per idling pattern, each with its own limit
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin lim = 765; send_idle_pct = 0; stall_pct = 0; end
                1: begin lim = -1; send_idle_pct = 50; stall_pct = 0; end
                2: begin lim = $urandom_range(0, 766) - 1; send_idle_pct = 0; stall_pct = 50; end
                default: begin lim = 0; send_idle_pct = 6; stall_pct = 6; end
            endcase
            write_limit(lim);
            if (ph == 2)
                hold_left = HOLD_CYCLES;
            case (ph)
                0: send_odd_file(FILE_HUGE);
                1, 2: send_image($urandom_range(1, 7), $urandom_range(1, 2));
                default:
                begin
                    send_odd_file(FILE_NEGATIVE);
                    send_odd_file(FILE_SHORT_HEADER);
                end
            endcase
        end

        drain();
        $display("covered %0d input bytes in %0d files under %0d written limits",
                 bytes_sent, files_sent, limits_used);
        $display("checked %0d output words, %0d mismatches", board.words_checked, board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> bmp_rgb_threshold_stream_top.f
+incdir+rtl
rtl/bmp_thr_pkg.sv
rtl/bmp_thr_outq.sv
rtl/bmp_thr_core.sv
rtl/bmp_rgb_threshold_stream_top.sv
tb/bmp_rgb_threshold_stream_top_tb.sv
